// ----- sv/column_compare_to_bitmap_macros.svh -----
// assertion macros for the column compare to bitmap block
`ifndef COLUMN_COMPARE_TO_BITMAP_MACROS_SVH
`define COLUMN_COMPARE_TO_BITMAP_MACROS_SVH

`ifndef ASSERT_OFF
`define CCB_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("ccb assertion failed: never");
`define CCB_ASSERT_NEXT(lbl, clk, rst, cond, conseq) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("ccb assertion failed: next");
`else
`define CCB_ASSERT_NEVER(lbl, clk, rst, expr)
`define CCB_ASSERT_NEXT(lbl, clk, rst, cond, conseq)
`endif

`endif

// ----- sv/ccb_pkg.sv -----
// shared types and constants of the column compare to bitmap block
package ccb_pkg;

   localparam int WORD_BITS_DEFAULT  = 64;
   localparam int COUNT_BITS_DEFAULT = 32;
   localparam int WORDNUM_BITS       = 26;
   localparam int COUNT_OUT_BITS     = 32;
   localparam int VALUE_BITS         = 32;
   localparam int OP_BITS            = 3;
   localparam int CSR_INDEX_BITS     = 8;
   localparam int CSR_DATA_BITS      = 32;
   localparam int MID_QUEUE_DEPTH    = 4;
   localparam int OUT_QUEUE_DEPTH    = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMPARE_OP = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_THRESHOLD  = 8'd1;

   typedef enum logic [OP_BITS-1:0] {
      OP_GT = 3'd0,
      OP_GE = 3'd1,
      OP_LT = 3'd2,
      OP_LE = 3'd3,
      OP_EQ = 3'd4,
      OP_NE = 3'd5
   } op_type;

   // classified request handed from front to back
   typedef struct packed {
      logic hit;
      logic last;
   } item_type;

   localparam int ITEM_BITS = $bits(item_type);

endpackage

// ----- sv/ccb_queue.sv -----
// small register-based first-in first-out queue
module ccb_queue #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_BITS'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- sv/ccb_front.sv -----
// front end: configuration registers and predicate test of each request
module ccb_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [ccb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [ccb_pkg::CSR_DATA_BITS-1:0]     csr_data,
   input  logic signed [ccb_pkg::VALUE_BITS-1:0] sample,
   input  logic                                  end_of_run,
   output ccb_pkg::item_type                     item
);

   ccb_pkg::op_type                       op_ff;
   logic signed [ccb_pkg::VALUE_BITS-1:0] threshold_ff;
   logic                                  hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= ccb_pkg::OP_GT;
         threshold_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            ccb_pkg::CSR_COMPARE_OP: begin
               op_ff <= ccb_pkg::op_type'(csr_data[ccb_pkg::OP_BITS-1:0]);
            end
            ccb_pkg::CSR_THRESHOLD: begin
               threshold_ff <= signed'(csr_data[ccb_pkg::VALUE_BITS-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // unknown predicate codes never match
   always_comb begin
      case (op_ff)
         ccb_pkg::OP_GT: hit = (sample >  threshold_ff);
         ccb_pkg::OP_GE: hit = (sample >= threshold_ff);
         ccb_pkg::OP_LT: hit = (sample <  threshold_ff);
         ccb_pkg::OP_LE: hit = (sample <= threshold_ff);
         ccb_pkg::OP_EQ: hit = (sample == threshold_ff);
         ccb_pkg::OP_NE: hit = (sample != threshold_ff);
         default:        hit = 1'b0;
      endcase
   end

   assign item.hit  = hit;
   assign item.last = end_of_run;

endmodule

// ----- sv/ccb_back.sv -----
// back end: packs match bits into words and keeps word and match counts
module ccb_back #(
   parameter int WORD_BITS  = ccb_pkg::WORD_BITS_DEFAULT,
   parameter int COUNT_BITS = ccb_pkg::COUNT_BITS_DEFAULT,
   parameter int RES_BITS   = WORD_BITS + ccb_pkg::WORDNUM_BITS + ccb_pkg::COUNT_OUT_BITS + 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  ccb_pkg::item_type item,
   output logic              item_take,
   input  logic              out_full,
   output logic              res_valid,
   output logic [RES_BITS-1:0] res_data
);

   localparam int POS_BITS = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0]              acc_ff, acc_in;
   logic [POS_BITS-1:0]               pos_ff, pos_in;
   logic [ccb_pkg::WORDNUM_BITS-1:0]  word_ff, word_in;
   logic [COUNT_BITS-1:0]             cnt_ff, cnt_in;
   logic [WORD_BITS-1:0]              acc_next;
   logic [COUNT_BITS-1:0]             cnt_next;
   logic                              word_full;
   logic                              emit;

   assign item_take = item_valid && !out_full;
   assign word_full = (pos_ff == POS_BITS'(WORD_BITS - 1));
   assign emit      = word_full || item.last;
   assign res_valid = item_take && emit;

   always_comb begin
      acc_next = acc_ff | ({{(WORD_BITS-1){1'b0}}, item.hit} << pos_ff);
      cnt_next = cnt_ff;
      // count saturates at all ones
      if (item.hit && !(&cnt_ff)) begin
         cnt_next = cnt_ff + 1'b1;
      end
   end

   assign res_data = {acc_next, word_ff, ccb_pkg::COUNT_OUT_BITS'(cnt_next), item.last};

   always_comb begin
      acc_in  = acc_ff;
      pos_in  = pos_ff;
      word_in = word_ff;
      cnt_in  = cnt_ff;
      if (item_take) begin
         if (emit) begin
            acc_in = '0;
            pos_in = '0;
            if (item.last) begin
               word_in = '0;
               cnt_in  = '0;
            end else begin
               word_in = word_ff + 1'b1;
               cnt_in  = cnt_next;
            end
         end else begin
            acc_in = acc_next;
            pos_in = pos_ff + 1'b1;
            cnt_in = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pos_ff  <= '0;
         word_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         word_ff <= word_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

// ----- sv/column_compare_to_bitmap.sv -----
// Column scan filter: each request is a signed value tested against a threshold under a
// programmable predicate; match bits are packed into WORD_BITS-wide words that come out
// when full or at end of run, with word number, saturating match count and a final flag.
// One request is taken every clock cycle while req_full is low. Requests are tested in
// the front stage and parked in a four-entry queue; the packing stage takes one per
// cycle while the two-entry result queue has room, so a stalled result side fills both
// queues before req_full rises. The configuration port is always ready and should be
// written only while the block is idle.
module column_compare_to_bitmap #(
   parameter int WORD_BITS  = ccb_pkg::WORD_BITS_DEFAULT,
   parameter int COUNT_BITS = ccb_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic signed [ccb_pkg::VALUE_BITS-1:0]  req_sample,
   input  logic                                   req_end_of_run,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [WORD_BITS-1:0]                   rsp_match_bits,
   output logic [ccb_pkg::WORDNUM_BITS-1:0]       rsp_word_number,
   output logic [ccb_pkg::COUNT_OUT_BITS-1:0]     rsp_matches_so_far,
   output logic                                   rsp_final_word,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ccb_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [ccb_pkg::CSR_DATA_BITS-1:0]      csr_data
);

`include "column_compare_to_bitmap_macros.svh"

   localparam int RES_BITS = WORD_BITS + ccb_pkg::WORDNUM_BITS + ccb_pkg::COUNT_OUT_BITS + 1;

   ccb_pkg::item_type   front_item;
   ccb_pkg::item_type   mid_item;
   logic [ccb_pkg::ITEM_BITS-1:0] mid_rd;
   logic                mid_empty;
   logic                req_accept;
   logic                item_take;
   logic                out_full;
   logic                res_valid;
   logic [RES_BITS-1:0] res_data;
   logic [RES_BITS-1:0] out_data;

   assign csr_ready  = 1'b1;
   assign req_accept = req_push && !req_full;

   ccb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .sample     (req_sample),
      .end_of_run (req_end_of_run),
      .item       (front_item)
   );

   ccb_queue #(
      .WIDTH (ccb_pkg::ITEM_BITS),
      .DEPTH (ccb_pkg::MID_QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (front_item),
      .full    (req_full),
      .pop     (item_take),
      .rd_data (mid_rd),
      .empty   (mid_empty)
   );

   assign mid_item = ccb_pkg::item_type'(mid_rd);

   ccb_back #(
      .WORD_BITS  (WORD_BITS),
      .COUNT_BITS (COUNT_BITS),
      .RES_BITS   (RES_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (!mid_empty),
      .item       (mid_item),
      .item_take  (item_take),
      .out_full   (out_full),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   ccb_queue #(
      .WIDTH (RES_BITS),
      .DEPTH (ccb_pkg::OUT_QUEUE_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (res_valid),
      .wr_data (res_data),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (out_data),
      .empty   (rsp_empty)
   );

   assign {rsp_match_bits, rsp_word_number, rsp_matches_so_far, rsp_final_word} = out_data;

   // an accepted request is waiting for the back end on the next cycle
   `CCB_ASSERT_NEXT(a_req_reaches_mid, clock, reset, req_accept, !mid_empty)
   // a result pushed into the output queue is visible on the next cycle
   `CCB_ASSERT_NEXT(a_res_reaches_out, clock, reset, res_valid, !rsp_empty)
   // the back end never takes a request while the result queue has no room
   `CCB_ASSERT_NEVER(a_no_take_when_full, clock, reset, item_take && out_full)

endmodule

// ----- bench/column_compare_to_bitmap_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench of the column compare to bitmap filter under random flow control
module column_compare_to_bitmap_tb;

   localparam int WORD_W        = ccb_pkg::WORD_BITS_DEFAULT;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int RANDOM_ITEMS  = 850;
   localparam int OP_CODES      = 1 << ccb_pkg::OP_BITS;
   localparam logic signed [ccb_pkg::VALUE_BITS-1:0] VALUE_MIN =
      {1'b1, {(ccb_pkg::VALUE_BITS-1){1'b0}}};
   localparam logic signed [ccb_pkg::VALUE_BITS-1:0] VALUE_MAX =
      {1'b0, {(ccb_pkg::VALUE_BITS-1){1'b1}}};

   typedef struct {
      logic [WORD_W-1:0]                  bits;
      logic [ccb_pkg::WORDNUM_BITS-1:0]   number;
      logic [ccb_pkg::COUNT_OUT_BITS-1:0] count;
      logic                               last;
   } bitmap_word_type;

   class bitmap_scoreboard_type;
      logic [ccb_pkg::OP_BITS-1:0]           predicate;
      logic signed [ccb_pkg::VALUE_BITS-1:0] limit;
      logic [WORD_W-1:0]                     acc_bits;
      int                                    fill;
      logic [ccb_pkg::WORDNUM_BITS-1:0]      word_index;
      logic [ccb_pkg::COUNT_OUT_BITS-1:0]    hit_count;
      bitmap_word_type                       expected_words[$];
      int                                    errors;
      int                                    words_checked;

      function new();
         predicate     = '0;
         limit         = '0;
         acc_bits      = '0;
         fill          = 0;
         word_index    = '0;
         hit_count     = '0;
         errors        = 0;
         words_checked = 0;
      endfunction

      function void note_config(input logic [ccb_pkg::CSR_INDEX_BITS-1:0] idx,
                                input logic [ccb_pkg::CSR_DATA_BITS-1:0] data);
         if (idx == ccb_pkg::CSR_COMPARE_OP) begin
            predicate = data[ccb_pkg::OP_BITS-1:0];
         end else if (idx == ccb_pkg::CSR_THRESHOLD) begin
            limit = data[ccb_pkg::VALUE_BITS-1:0];
         end
      endfunction

      function void note_request(input logic signed [ccb_pkg::VALUE_BITS-1:0] sample,
                                 input logic run_end);
         logic            hit;
         bitmap_word_type w;
         case (predicate)
            ccb_pkg::OP_GT: hit = sample > limit;
            ccb_pkg::OP_GE: hit = sample >= limit;
            ccb_pkg::OP_LT: hit = sample < limit;
            ccb_pkg::OP_LE: hit = sample <= limit;
            ccb_pkg::OP_EQ: hit = sample == limit;
            ccb_pkg::OP_NE: hit = sample != limit;
            default:        hit = 1'b0;
         endcase
         if (hit) begin
            acc_bits[fill] = 1'b1;
            if (hit_count != '1) hit_count = hit_count + 1'b1;
         end
         fill++;
         if (fill == WORD_W || run_end) begin
            w.bits   = acc_bits;
            w.number = word_index;
            w.count  = hit_count;
            w.last   = run_end;
            expected_words.push_back(w);
            acc_bits = '0;
            fill     = 0;
            if (run_end) begin
               word_index = '0;
               hit_count  = '0;
            end else begin
               word_index = word_index + 1'b1;
            end
         end
      endfunction

      function void check_result(input logic [WORD_W-1:0] bits,
                                 input logic [ccb_pkg::WORDNUM_BITS-1:0] number,
                                 input logic [ccb_pkg::COUNT_OUT_BITS-1:0] count,
                                 input logic last);
         bitmap_word_type w;
         if (expected_words.size() == 0) begin
            $error("unexpected bitmap word: match_bits %h word_number %0d", bits, number);
            errors++;
         end else begin
            w = expected_words.pop_front();
            words_checked++;
            if (bits !== w.bits) begin
               $error("match_bits: expected %h, got %h", w.bits, bits);
               errors++;
            end
            if (number !== w.number) begin
               $error("word_number: expected %0d, got %0d", w.number, number);
               errors++;
            end
            if (count !== w.count) begin
               $error("matches_so_far: expected %0d, got %0d", w.count, count);
               errors++;
            end
            if (last !== w.last) begin
               $error("final_word: expected %b, got %b", w.last, last);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic                                   clock          = 1'b0;
   logic                                   reset          = 1'b1;
   logic                                   req_push       = 1'b0;
   logic                                   req_full;
   logic signed [ccb_pkg::VALUE_BITS-1:0]  req_sample     = '0;
   logic                                   req_end_of_run = 1'b0;
   logic                                   rsp_empty;
   logic                                   rsp_pop        = 1'b0;
   logic [WORD_W-1:0]                      rsp_match_bits;
   logic [ccb_pkg::WORDNUM_BITS-1:0]       rsp_word_number;
   logic [ccb_pkg::COUNT_OUT_BITS-1:0]     rsp_matches_so_far;
   logic                                   rsp_final_word;
   logic                                   csr_valid      = 1'b0;
   logic                                   csr_ready;
   logic [ccb_pkg::CSR_INDEX_BITS-1:0]     csr_index      = '0;
   logic [ccb_pkg::CSR_DATA_BITS-1:0]      csr_data       = '0;

   bitmap_scoreboard_type board = new();
   int cycle_count = 0;
   int items_sent  = 0;
   int burst_left  = 0;
   int pop_mode    = 0;
   int pop_hold    = 0;

   column_compare_to_bitmap u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_sample         (req_sample),
      .req_end_of_run     (req_end_of_run),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_match_bits     (rsp_match_bits),
      .rsp_word_number    (rsp_word_number),
      .rsp_matches_so_far (rsp_matches_so_far),
      .rsp_final_word     (rsp_final_word),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial forever #1 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("column_compare_to_bitmap_tb: done, errors");
      $finish;
   end

   // all handshakes sampled on pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.note_config(csr_index, csr_data);
         if (rsp_pop && !rsp_empty) begin
            board.check_result(rsp_match_bits, rsp_word_number, rsp_matches_so_far,
                               rsp_final_word);
         end
         if (req_push && !req_full) board.note_request(req_sample, req_end_of_run);
      end
   end

   // receiver switches between stall patterns, holding each for a random span
   always @(posedge clock) begin
      if (pop_hold == 0) begin
         pop_mode <= $urandom_range(0, 3);
         pop_hold <= $urandom_range(8, 150);
      end else begin
         pop_hold <= pop_hold - 1;
      end
      case (pop_mode)
         0:       rsp_pop <= 1'b1;
         1:       rsp_pop <= 1'($urandom_range(0, 1));
         2:       rsp_pop <= ($urandom_range(0, 7) == 0);
         default: rsp_pop <= (pop_hold % 6 == 0);
      endcase
   end

   task automatic push_sample(input logic signed [ccb_pkg::VALUE_BITS-1:0] sample,
                              input logic run_end);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      items_sent++;
      req_push       <= 1'b1;
      req_sample     <= sample;
      req_end_of_run <= run_end;
      do @(posedge clock); while (req_full);
   endtask

   task automatic write_register(input logic [ccb_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input logic [ccb_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // op bits go in the low field, upper data bits random
   task automatic program_block(input logic [ccb_pkg::OP_BITS-1:0] op,
                                input logic signed [ccb_pkg::VALUE_BITS-1:0] thr,
                                input logic spare_write);
      write_register(ccb_pkg::CSR_COMPARE_OP, ($urandom & ~(OP_CODES - 1)) | op);
      write_register(ccb_pkg::CSR_THRESHOLD, thr);
      if (spare_write) begin
         write_register(ccb_pkg::CSR_INDEX_BITS'($urandom_range(ccb_pkg::CSR_THRESHOLD + 1,
                                                                255)), $urandom);
      end
      csr_valid <= 1'b0;
   endtask

   // holds the sender until every word is out and the pipeline has emptied
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [ccb_pkg::VALUE_BITS-1:0] pick_sample(
      input logic signed [ccb_pkg::VALUE_BITS-1:0] thr);
      int delta;
      delta = $urandom_range(0, 4);
      case ($urandom_range(0, 7))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3:    return thr + delta - 2;
         4:       return $urandom_range(0, 1) ? '0 : '1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic signed [ccb_pkg::VALUE_BITS-1:0] thr;
      logic [ccb_pkg::OP_BITS-1:0]           op;
      int                                    runs;
      int                                    run_len;
      logic                                  close;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // out of reset: greater than zero
      push_sample('0, 1'b0);
      push_sample(1, 1'b0);
      push_sample(-1, 1'b0);
      push_sample(VALUE_MIN, 1'b0);
      push_sample(VALUE_MAX, 1'b1);
      drain();

      // remaining predicates and the two unknown codes around extreme thresholds
      for (int k = int'(ccb_pkg::OP_GE); k < OP_CODES; k++) begin
         thr = k[0] ? VALUE_MIN : VALUE_MAX;
         program_block(k[ccb_pkg::OP_BITS-1:0], thr, 1'b0);
         push_sample(thr - 1, 1'b0);
         push_sample(thr, 1'b0);
         push_sample(thr + 1, k == OP_CODES - 1);
         drain();
      end

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            op = ccb_pkg::OP_BITS'($urandom_range(int'(ccb_pkg::OP_NE) + 1, OP_CODES - 1));
         end else begin
            op = ccb_pkg::OP_BITS'($urandom_range(ccb_pkg::OP_GT, ccb_pkg::OP_NE));
         end
         case ($urandom_range(0, 5))
            0:       thr = VALUE_MIN;
            1:       thr = VALUE_MAX;
            2:       thr = '0;
            default: thr = $urandom;
         endcase
         program_block(op, thr, $urandom_range(0, 5) == 0);
         runs = $urandom_range(1, 4);
         for (int r = 0; r < runs; r++) begin
            case ($urandom_range(0, 5))
               0:       run_len = $urandom_range(1, 4);
               1:       run_len = WORD_W;
               2:       run_len = 2 * WORD_W;
               3:       run_len = $urandom_range(WORD_W + 1, 2 * WORD_W + 4);
               default: run_len = $urandom_range(5, WORD_W - 1);
            endcase
            // leave the last run open now and then so the next setting lands mid-word
            close = !(r == runs - 1 && $urandom_range(0, 3) == 0);
            for (int n = 1; n <= run_len; n++) push_sample(pick_sample(thr), n == run_len && close);
         end
         drain();
      end

      if (board.errors == 0) begin
         $display("column_compare_to_bitmap_tb: done, clean");
      end else begin
         $display("column_compare_to_bitmap_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/ccb_pkg.sv
sv/ccb_queue.sv
sv/ccb_front.sv
sv/ccb_back.sv
sv/column_compare_to_bitmap.sv
bench/column_compare_to_bitmap_tb.sv
